### rtl/phd_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the pH dose calculator.
package phd_pkg;

    // Field widths fixed by the interface
    localparam int PH_W      = 12;
    localparam int LITRES_W  = 12;
    localparam int KIND_W    = 2;
    localparam int DOSE_W    = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 12;

    // Defaults for the top-level parameters
    localparam int DEF_PH_FRAC_BITS    = 8;
    localparam int DEF_EXP_TABLE_DEPTH = 256;

    // Dose kinds
    localparam logic [KIND_W-1:0] DOSE_NONE = 2'd0;
    localparam logic [KIND_W-1:0] DOSE_ACID = 2'd1;
    localparam logic [KIND_W-1:0] DOSE_BASE = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PH_LOW_LIMIT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PH_HIGH_LIMIT = 1'd1;

    // Reset values of the band limits (6.0 and 7.5 with 8 fraction bits)
    localparam logic [PH_W-1:0] PH_LOW_RESET  = 12'd1536;
    localparam logic [PH_W-1:0] PH_HIGH_RESET = 12'd1920;

    // Arithmetic constants
    localparam int                 PH_NEUTRAL_X2 = 14;
    localparam logic [33:0]        LOG2_10_Q32   = 34'h35269E12F;
    localparam logic [63:0]        LN2_Q60       = 64'h0B17217F7D1CF79B;
    localparam int                 LSC_W         = 32;
    localparam logic [LSC_W-1:0]   LITRE_SCALE   = 32'd1000000;
    localparam int                 ENTRY_W       = 31;
    localparam int                 TERM_W        = 63;
    localparam int                 QUEUE_DEPTH   = 4;

    // Width of an exponent held with one extra fraction bit
    function automatic int x_width(input int frac_bits);
        return (frac_bits + 5 > 13) ? frac_bits + 5 : 13;
    endfunction

    typedef struct packed {
        logic [PH_W-1:0]     ph_sample;
        logic [LITRES_W-1:0] tank_litres;
    } phd_in_t;

    typedef struct packed {
        logic [KIND_W-1:0] dose_kind;
        logic [DOSE_W-1:0] dose_microlitres;
    } phd_out_t;

endpackage

### rtl/phd_front.sv
`timescale 1ns / 1ps
// Front end: band limits, classification and exponent set-up per request.
module phd_front #(
    parameter int PH_FRAC_BITS = phd_pkg::DEF_PH_FRAC_BITS,
    parameter int TASK_W       = 2 + 2 * phd_pkg::x_width(phd_pkg::DEF_PH_FRAC_BITS) + 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [phd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [phd_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          push,
    input  phd_pkg::phd_in_t              sample,
    input  logic                          q_full,
    output logic                          q_wr,
    output logic [TASK_W-1:0]             q_word
);
    import phd_pkg::*;

    localparam int XW = x_width(PH_FRAC_BITS);
    localparam logic [XW-1:0] FOURTEEN2 = XW'(PH_NEUTRAL_X2) << (PH_FRAC_BITS + 1);

    logic [PH_W-1:0]   ph_low_limit_reg;
    logic [PH_W-1:0]   ph_high_limit_reg;
    logic [KIND_W-1:0] kind;
    logic [XW-1:0]     goal2;
    logic [XW-1:0]     ph2;
    logic [XW-1:0]     xa;
    logic [XW-1:0]     xb;
    logic [LSC_W-1:0]  lsc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_low_limit_reg  <= PH_LOW_RESET;
            ph_high_limit_reg <= PH_HIGH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PH_LOW_LIMIT:  ph_low_limit_reg  <= cfg_data;
                REG_PH_HIGH_LIMIT: ph_high_limit_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        goal2 = XW'(ph_low_limit_reg) + XW'(ph_high_limit_reg);
        ph2   = XW'(sample.ph_sample) << 1;
        kind  = DOSE_NONE;
        xa    = '0;
        xb    = '0;
        // on a limit, or inside the band: no dose
        if (ph_low_limit_reg < sample.ph_sample && sample.ph_sample < ph_high_limit_reg)
        begin
            kind = DOSE_NONE;
        end
        else if (sample.ph_sample > ph_high_limit_reg)
        begin
            kind = DOSE_ACID;
            xa   = goal2;
            xb   = ph2;
        end
        else if (sample.ph_sample < ph_low_limit_reg)
        begin
            // base side works on pOH, clamped at zero
            kind = DOSE_BASE;
            xa   = (goal2 < FOURTEEN2) ? FOURTEEN2 - goal2 : '0;
            xb   = (ph2 < FOURTEEN2) ? FOURTEEN2 - ph2 : '0;
        end
        lsc = LSC_W'(sample.tank_litres) * LITRE_SCALE;
    end

    assign q_wr   = push && !q_full;
    assign q_word = {kind, xa, xb, lsc};

endmodule

### rtl/phd_fifo.sv
`timescale 1ns / 1ps
// Short request queue between front end and dose pipeline.
module phd_fifo #(
    parameter int WIDTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);
    import phd_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (rd)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (wr && !rd)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (rd && !wr)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    assign rd_data = mem_reg[rd_ptr_reg];
    assign full    = (count_reg == CW'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);

endmodule

### rtl/phd_back.sv
`timescale 1ns / 1ps
// Dose pipeline: power-of-ten terms for goal and sample, difference, rounding.
module phd_back #(
    parameter int PH_FRAC_BITS    = phd_pkg::DEF_PH_FRAC_BITS,
    parameter int EXP_TABLE_DEPTH = phd_pkg::DEF_EXP_TABLE_DEPTH,
    parameter int TASK_W          = 2 + 2 * phd_pkg::x_width(phd_pkg::DEF_PH_FRAC_BITS) + 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  logic [TASK_W-1:0] q_word,
    output logic              q_rd,
    input  logic              pop,
    output logic              empty,
    output phd_pkg::phd_out_t dose
);
    import phd_pkg::*;

    localparam int XW  = x_width(PH_FRAC_BITS);
    localparam int YW  = XW + 34;
    localparam int FB  = 33 + PH_FRAC_BITS;
    localparam int NW  = YW - FB;
    localparam int AW  = $clog2(EXP_TABLE_DEPTH);
    localparam int IW  = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int PRW = FB + IW;
    localparam int NS  = 7;

    typedef logic [ENTRY_W-1:0] rom_t [EXP_TABLE_DEPTH];

    // entry i = round(2^-(i/depth) * 2^30), series for exp(-u) in Q60
    function automatic rom_t build_rom();
        rom_t         rom;
        logic [63:0]  u;
        logic [63:0]  sum;
        logic [63:0]  term;
        logic [127:0] prod;
        int unsigned  i;
        int unsigned  k;
        for (i = 0; i < EXP_TABLE_DEPTH; i++)
        begin
            u = (LN2_Q60 / 64'(EXP_TABLE_DEPTH)) * 64'(i)
              + ((LN2_Q60 % 64'(EXP_TABLE_DEPTH)) * 64'(i)) / 64'(EXP_TABLE_DEPTH);
            sum  = 64'd1 << 60;
            term = 64'd1 << 60;
            for (k = 1; k <= 30; k++)
            begin
                prod = {64'd0, term} * {64'd0, u};
                term = prod[123:60] / 64'(k);
                if (k[0])
                    sum = sum - term;
                else
                    sum = sum + term;
            end
            rom[i] = ENTRY_W'((sum + (64'd1 << 29)) >> 30);
        end
        return rom;
    endfunction

    localparam rom_t EXP_ROM = build_rom();

    logic [KIND_W-1:0] h_kind;
    logic [XW-1:0]     h_xa;
    logic [XW-1:0]     h_xb;
    logic [LSC_W-1:0]  h_lsc;

    logic [NS-1:0] stage_v_reg;
    logic [NS-1:0] stage_v_next;
    logic [NS-1:0] rdy;

    // lane 0: goal term, lane 1: sample term
    logic [KIND_W-1:0]  s1_kind_reg;
    logic [LSC_W-1:0]   s1_lsc_reg;
    logic [YW-1:0]      s1_y_reg [2];

    logic [KIND_W-1:0]  s2_kind_reg;
    logic [LSC_W-1:0]   s2_lsc_reg;
    logic [AW-1:0]      s2_idx_reg [2];
    logic [5:0]         s2_n_reg [2];
    logic [1:0]         s2_zero_reg;
    logic [AW-1:0]      s2_idx_next [2];
    logic [5:0]         s2_n_next [2];
    logic [1:0]         s2_zero_next;

    logic [KIND_W-1:0]  s3_kind_reg;
    logic [LSC_W-1:0]   s3_lsc_reg;
    logic [ENTRY_W-1:0] s3_entry_reg [2];
    logic [5:0]         s3_n_reg [2];
    logic [1:0]         s3_zero_reg;

    logic [KIND_W-1:0]  s4_kind_reg;
    logic [TERM_W-1:0]  s4_m_reg [2];
    logic [5:0]         s4_n_reg [2];
    logic [1:0]         s4_zero_reg;

    logic [KIND_W-1:0]  s5_kind_reg;
    logic [TERM_W-1:0]  s5_t_reg [2];

    logic [KIND_W-1:0]  s6_kind_reg;
    logic [TERM_W-1:0]  s6_diff_reg;
    logic               s6_pos_reg;

    logic [KIND_W-1:0]  s7_kind_reg;
    logic [DOSE_W-1:0]  s7_dose_reg;
    logic [DOSE_W-1:0]  s7_dose_next;

    assign {h_kind, h_xa, h_xb, h_lsc} = q_word;

    // A stage takes new data when it is empty or its successor moves.
    always_comb
    begin
        rdy[NS-1] = !stage_v_reg[NS-1] || pop;
        for (int s = NS - 2; s >= 0; s--)
        begin
            rdy[s] = !stage_v_reg[s] || rdy[s+1];
        end
        stage_v_next[0] = rdy[0] ? !q_empty : stage_v_reg[0];
        for (int s = 1; s < NS; s++)
        begin
            stage_v_next[s] = rdy[s] ? stage_v_reg[s-1] : stage_v_reg[s];
        end
    end

    assign q_rd = rdy[0] && !q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_v_reg <= '0;
        end
        else
        begin
            stage_v_reg <= stage_v_next;
        end
    end

    // Integer part of x*log2(10) is the shift, fraction picks the table entry.
    always_comb
    begin
        logic [FB-1:0]  frac;
        logic [PRW-1:0] prod;
        logic [IW-1:0]  idx_full;
        logic           wrap;
        logic [NW:0]    n_full;
        for (int l = 0; l < 2; l++)
        begin
            frac     = s1_y_reg[l][FB-1:0];
            prod     = PRW'(frac) * PRW'(EXP_TABLE_DEPTH) + (PRW'(1) << (FB - 1));
            idx_full = prod[PRW-1:FB];
            wrap     = (idx_full >= IW'(EXP_TABLE_DEPTH));
            n_full   = (NW + 1)'(s1_y_reg[l][YW-1:FB]) + (NW + 1)'(wrap);
            s2_zero_next[l] = (n_full >= (NW + 1)'(64));
            s2_n_next[l]    = n_full[5:0];
            s2_idx_next[l]  = wrap ? '0 : idx_full[AW-1:0];
        end
    end

    always_comb
    begin
        logic [TERM_W:0] rounded;
        rounded = {1'b0, s6_diff_reg} + ((TERM_W + 1)'(1) << 29);
        if (!s6_pos_reg)
            s7_dose_next = '0;
        else if (rounded[TERM_W:30 + DOSE_W] != '0)
            s7_dose_next = '1;
        else
            s7_dose_next = rounded[30 + DOSE_W - 1:30];
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            s1_kind_reg <= h_kind;
            s1_lsc_reg  <= h_lsc;
            s1_y_reg[0] <= YW'(h_xa) * YW'(LOG2_10_Q32);
            s1_y_reg[1] <= YW'(h_xb) * YW'(LOG2_10_Q32);
        end
        if (rdy[1])
        begin
            s2_kind_reg <= s1_kind_reg;
            s2_lsc_reg  <= s1_lsc_reg;
            s2_idx_reg  <= s2_idx_next;
            s2_n_reg    <= s2_n_next;
            s2_zero_reg <= s2_zero_next;
        end
        if (rdy[2])
        begin
            s3_kind_reg     <= s2_kind_reg;
            s3_lsc_reg      <= s2_lsc_reg;
            s3_entry_reg[0] <= EXP_ROM[s2_idx_reg[0]];
            s3_entry_reg[1] <= EXP_ROM[s2_idx_reg[1]];
            s3_n_reg        <= s2_n_reg;
            s3_zero_reg     <= s2_zero_reg;
        end
        if (rdy[3])
        begin
            s4_kind_reg <= s3_kind_reg;
            s4_m_reg[0] <= TERM_W'(s3_entry_reg[0]) * TERM_W'(s3_lsc_reg);
            s4_m_reg[1] <= TERM_W'(s3_entry_reg[1]) * TERM_W'(s3_lsc_reg);
            s4_n_reg    <= s3_n_reg;
            s4_zero_reg <= s3_zero_reg;
        end
        if (rdy[4])
        begin
            s5_kind_reg <= s4_kind_reg;
            s5_t_reg[0] <= s4_zero_reg[0] ? '0 : s4_m_reg[0] >> s4_n_reg[0];
            s5_t_reg[1] <= s4_zero_reg[1] ? '0 : s4_m_reg[1] >> s4_n_reg[1];
        end
        if (rdy[5])
        begin
            s6_kind_reg <= s5_kind_reg;
            s6_pos_reg  <= (s5_t_reg[0] > s5_t_reg[1]);
            s6_diff_reg <= s5_t_reg[0] - s5_t_reg[1];
        end
        if (rdy[6])
        begin
            s7_kind_reg <= s6_kind_reg;
            s7_dose_reg <= s7_dose_next;
        end
    end

    assign empty                 = !stage_v_reg[NS-1];
    assign dose.dose_kind        = s7_kind_reg;
    assign dose.dose_microlitres = s7_dose_reg;

endmodule

### rtl/ph_dose_calculator.sv
`timescale 1ns / 1ps
// Top level of the pH dose calculator: front end, request queue, dose pipeline.
// Path: a request is written into the request queue, then passes the seven stages
//   of the dose pipeline (multiply, table index, table read, volume multiply, shift,
//   subtract, round/saturate).
// Throughput: one request per cycle; each stage holds only while its successor stalls.
// Reset (rst_n, async, active low): band limits go to 6.0 and 7.5, queue and
//   pipeline empty. The exponent table is constant, so no clearing pass is needed.
module ph_dose_calculator #(
    parameter int PH_FRAC_BITS    = phd_pkg::DEF_PH_FRAC_BITS,
    parameter int EXP_TABLE_DEPTH = phd_pkg::DEF_EXP_TABLE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration writes
    input  logic                          cfg_we,
    input  logic [phd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [phd_pkg::CFG_W-1:0]     cfg_data,
    // request side
    input  logic                          push,
    output logic                          full,
    input  phd_pkg::phd_in_t              sample,
    // result side
    output logic                          empty,
    input  logic                          pop,
    output phd_pkg::phd_out_t             dose
);
    import phd_pkg::*;

    // queued request: kind, goal exponent, sample exponent, litres * 1e6
    localparam int XW     = x_width(PH_FRAC_BITS);
    localparam int TASK_W = KIND_W + 2 * XW + LSC_W;

    logic              q_wr;
    logic              q_rd;
    logic              q_full;
    logic              q_empty;
    logic [TASK_W-1:0] q_wdata;
    logic [TASK_W-1:0] q_rdata;

    // Front end: classifies against the band and forms both exponents.
    phd_front #(
        .PH_FRAC_BITS (PH_FRAC_BITS),
        .TASK_W       (TASK_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .sample    (sample),
        .q_full    (q_full),
        .q_wr      (q_wr),
        .q_word    (q_wdata)
    );

    // Decoupling queue; the front refuses requests only while the queue is full.
    phd_fifo #(
        .WIDTH (TASK_W)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_data (q_wdata),
        .rd      (q_rd),
        .rd_data (q_rdata),
        .full    (q_full),
        .empty   (q_empty)
    );

    // Back end: evaluates both terms and the rounded, saturated dose.
    phd_back #(
        .PH_FRAC_BITS    (PH_FRAC_BITS),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH),
        .TASK_W          (TASK_W)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_word  (q_rdata),
        .q_rd    (q_rd),
        .pop     (pop),
        .empty   (empty),
        .dose    (dose)
    );

    assign full = q_full;

    // no dose kind means a zero volume
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && dose.dose_kind == DOSE_NONE) |-> dose.dose_microlitres == '0)
        else $error("dose given with no dose kind");

    // a shown result never carries an undefined kind code
    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (dose.dose_kind == DOSE_NONE || dose.dose_kind == DOSE_ACID ||
                    dose.dose_kind == DOSE_BASE))
        else $error("undefined dose kind on result");

    // queue is never written while full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_wr |-> !q_full)
        else $error("request queue overflow");

    // queue is never read while empty
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_rd |-> !q_empty)
        else $error("request queue underflow");

endmodule
